FILE: sv/geiv_pkg.sv
// Shared types and constants for the GPIO edge interrupt vectoring block.
// Holds the payload structs, register indexes and operation codes; no dependencies.
`timescale 1ns / 1ps

package geiv_pkg;

   localparam int PIN_COUNT = 32;
   localparam int PIN_WIDTH = 5;
   localparam int WORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   // Pins at or above PIN_COUNT are forced to zero everywhere.
   localparam logic [WORD_WIDTH-1:0] PIN_MASK =
      WORD_WIDTH'((64'd1 << PIN_COUNT) - 64'd1);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RISE_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FALL_ENABLE = 1'd1;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   localparam logic EDGE_RISING  = 1'b0;
   localparam logic EDGE_FALLING = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [WORD_WIDTH-1:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic                  irq_pending;
      logic                  vector_valid;
      logic                  vector_edge;
      logic [PIN_WIDTH-1:0]  vector_pin;
      logic [WORD_WIDTH-1:0] rise_status;
      logic [WORD_WIDTH-1:0] fall_status;
   } rsp_type;

endpackage

FILE: sv/geiv_prio_enc.sv
// Five-level binary-search priority encoder: index of the highest set bit.
// Depends on geiv_pkg for the word and pin widths.
`timescale 1ns / 1ps

module geiv_prio_enc (
   input  logic [geiv_pkg::WORD_WIDTH-1:0] word,
   output logic [geiv_pkg::PIN_WIDTH-1:0]  pin
);
   import geiv_pkg::*;

   always_comb begin
      logic [WORD_WIDTH-1:0] v;
      logic [PIN_WIDTH-1:0]  pos;
      v   = word;
      pos = '0;
      // Halve the window each level, keeping the upper half when it holds a bit.
      for (int lvl = PIN_WIDTH - 1; lvl >= 0; lvl--) begin
         if ((v >> (1 << lvl)) != '0) begin
            v   = v >> (1 << lvl);
            pos = pos | PIN_WIDTH'(1 << lvl);
         end
      end
      pin = pos;
   end

endmodule

FILE: sv/gpio_edge_interrupt_vectoring.sv
// GPIO edge interrupt vectoring block: edge detection, sticky pending bits and
// the priority vector. Depends on geiv_pkg and geiv_prio_enc.
//
// Usage:
//   req channel (req_valid / req_stall / req_payload): op selects a sample of the
//   pin levels or a service of the highest pending interrupt. Every transfer
//   yields exactly one transfer on the rsp channel (rsp_valid / rsp_stall /
//   rsp_payload) carrying the vector and the pending status after that step.
//   csr port: csr_write_enable with csr_index 0 writes the rising enable mask,
//   index 1 the falling enable mask; write only while no result is in flight.
//   Output: each result is registered in the result register, or in the skid
//   register while a stalled result waits. Throughput: one item per cycle while
//   req_stall is low; edge detect, pending update and the five-level priority
//   encode all settle combinationally between request and result register.
//   Stall: a two-entry output buffer (result register plus skid register)
//   keeps taking requests while one result waits; req_stall rises only once
//   the skid register is full and drops as soon as the receiver drains it.
//   Reset: synchronous, clears enables, previous levels, pending bits and
//   both output valid flags.
`timescale 1ns / 1ps

module gpio_edge_interrupt_vectoring (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  geiv_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output geiv_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [geiv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [geiv_pkg::WORD_WIDTH-1:0]       csr_wdata
);
   import geiv_pkg::*;

   logic [WORD_WIDTH-1:0] rise_enable_ff, fall_enable_ff;
   logic [WORD_WIDTH-1:0] prev_levels_ff, prev_levels_in;
   logic [WORD_WIDTH-1:0] rise_pending_ff, rise_pending_in;
   logic [WORD_WIDTH-1:0] fall_pending_ff, fall_pending_in;

   rsp_type out_ff, skid_ff, result_in;
   logic    out_valid_ff, skid_valid_ff;

   logic                  req_transfer, rsp_transfer;
   logic [WORD_WIDTH-1:0] levels, pick_set, clear_mask;
   logic                  use_rise, found;
   logic [PIN_WIDTH-1:0]  pick_pin;

   assign req_stall    = skid_valid_ff;
   assign req_transfer = req_valid && !skid_valid_ff;
   assign rsp_transfer = out_valid_ff && !rsp_stall;
   assign rsp_valid    = out_valid_ff;
   assign rsp_payload  = out_ff;

   assign levels   = req_payload.pin_levels & PIN_MASK;
   assign use_rise = (rise_pending_ff != '0);
   assign pick_set = use_rise ? rise_pending_ff : fall_pending_ff;
   assign found    = (pick_set != '0);

   geiv_prio_enc u_prio_enc (
      .word (pick_set),
      .pin  (pick_pin)
   );

   assign clear_mask = ~(WORD_WIDTH'(1) << pick_pin);

   always_comb begin
      prev_levels_in  = prev_levels_ff;
      rise_pending_in = rise_pending_ff;
      fall_pending_in = fall_pending_ff;
      result_in       = '0;
      case (req_payload.op)
         OP_SAMPLE: begin
            rise_pending_in = (rise_pending_ff | (levels & ~prev_levels_ff & rise_enable_ff))
                              & PIN_MASK;
            fall_pending_in = (fall_pending_ff | (prev_levels_ff & ~levels & fall_enable_ff))
                              & PIN_MASK;
            prev_levels_in  = levels;
         end
         OP_SERVICE: begin
            if (found) begin
               rise_pending_in        = rise_pending_ff & clear_mask;
               fall_pending_in        = fall_pending_ff & clear_mask;
               result_in.vector_valid = 1'b1;
               result_in.vector_edge  = use_rise ? EDGE_RISING : EDGE_FALLING;
               result_in.vector_pin   = pick_pin;
            end
         end
         default: begin
         end
      endcase
      result_in.irq_pending = ((rise_pending_in | fall_pending_in) != '0);
      result_in.rise_status = rise_pending_in;
      result_in.fall_status = fall_pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_enable_ff  <= '0;
         fall_enable_ff  <= '0;
         prev_levels_ff  <= '0;
         rise_pending_ff <= '0;
         fall_pending_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RISE_ENABLE: rise_enable_ff <= csr_wdata;
               CSR_FALL_ENABLE: fall_enable_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_transfer) begin
            prev_levels_ff  <= prev_levels_in;
            rise_pending_ff <= rise_pending_in;
            fall_pending_ff <= fall_pending_in;
         end
      end
   end

   // Output buffer: the skid entry always drains into the result register first.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_transfer) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_transfer) begin
         if (!out_valid_ff || rsp_transfer) begin
            out_ff       <= result_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_transfer) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

FILE: sv/geiv_checker.sv
// Port-level checks for gpio_edge_interrupt_vectoring, attached by bind.
// Depends on geiv_pkg for the payload types.
`timescale 1ns / 1ps

module geiv_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input geiv_pkg::rsp_type                     rsp_payload
);
   import geiv_pkg::*;

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_irq_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.irq_pending ==
                    ((rsp_payload.rise_status | rsp_payload.fall_status) != '0))
      else $error("irq_pending disagrees with status");

   a_empty_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.vector_valid |->
         rsp_payload.vector_edge == EDGE_RISING && rsp_payload.vector_pin == '0)
      else $error("vector fields set without a vector");

   // A serviced pin has both pending bits dropped.
   a_serviced_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.vector_valid |->
         !rsp_payload.rise_status[rsp_payload.vector_pin] &&
         !rsp_payload.fall_status[rsp_payload.vector_pin])
      else $error("serviced pin still pending");

endmodule

bind gpio_edge_interrupt_vectoring geiv_checker u_geiv_checker (.*);
